@@ rtl/frra_pkg.sv @@
// Shared types and constants for the fair ring resource arbiter.
package frra_pkg;

	localparam int AGENT_W  = 3;
	localparam int WEIGHT_W = 4;
	localparam int TOTAL_W  = 16;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		ST_THINKING = 2'd0,
		ST_HUNGRY   = 2'd1,
		ST_EATING   = 2'd2
	} status_t;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Per-agent update strobes for one processed beat
	typedef struct packed {
		logic                grant;
		logic                set_hungry;
		logic                release_en;
		logic [WEIGHT_W-1:0] weight;
	} cell_ctl_t;

	typedef struct packed {
		logic               last;
		logic [AGENT_W-1:0] agent;
	} out_item_t;

endpackage

@@ rtl/fair_ring_resource_arbiter.sv @@
// Fair ring resource arbiter: input register, agent cells, grant logic, result buffer.
// Grants pass the input register, then the result buffer. Throughput: one beat per cycle
// while each beat yields at most one grant and m_axis_tready stays high; a release yielding
// two grants holds the next beat until the one-result-per-cycle output register drains.
// Reset (arst_n low): all agents thinking, totals zero, no beats pending; ready at once.
module fair_ring_resource_arbiter #(
	parameter int NUM_AGENTS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [2:0] agent_index, [6:3] usage_weight, [7] zero
	input  logic [0:0] s_axis_tuser,   // [0] operation
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [2:0] granted_agent, [7:3] zero
	output logic       m_axis_tlast
);

	localparam int AGW = $clog2(NUM_AGENTS);
	localparam int EW  = (AGW > frra_pkg::AGENT_W) ? AGW : frra_pkg::AGENT_W;
	localparam logic [AGW-1:0] LAST_IDX = AGW'(NUM_AGENTS - 1);

	// input register
	logic                           v_s1;
	frra_pkg::op_t                  op_s1;
	logic [frra_pkg::AGENT_W-1:0]   idx_s1;
	logic [frra_pkg::WEIGHT_W-1:0]  w_s1;

	logic proceed;
	logic can_load;

	assign s_axis_tready = !v_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1  <= frra_pkg::op_t'(s_axis_tuser[0]);
			idx_s1 <= s_axis_tdata[2:0];
			w_s1   <= s_axis_tdata[6:3];
		end
	end

	assign proceed = v_s1 && can_load;

	// agent index and its ring neighbours
	logic [EW-1:0]  idx_ext;
	logic [AGW-1:0] a;
	logic [AGW-1:0] l;
	logic [AGW-1:0] r;
	logic           in_range;

	assign idx_ext  = EW'(idx_s1);
	assign a        = idx_ext[AGW-1:0];
	assign in_range = (32'(idx_s1) < NUM_AGENTS);
	assign l        = (a == '0) ? LAST_IDX : a - AGW'(1);
	assign r        = (a == LAST_IDX) ? '0 : a + AGW'(1);

	// cells
	frra_pkg::status_t            st  [NUM_AGENTS];
	logic [frra_pkg::TOTAL_W-1:0] tot [NUM_AGENTS];
	frra_pkg::cell_ctl_t          ctl [NUM_AGENTS];
	logic [NUM_AGENTS-1:0]        okl;
	logic [NUM_AGENTS-1:0]        okr;
	logic [NUM_AGENTS-1:0]        hv;

	genvar j;
	generate
		for (j = 0; j < NUM_AGENTS; j++) begin : g_cell
			localparam int LI = (j == 0) ? NUM_AGENTS - 1 : j - 1;
			localparam int RI = (j == NUM_AGENTS - 1) ? 0 : j + 1;
			frra_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (ctl[j]),
				.left_status  (st[LI]),
				.left_total   (tot[LI]),
				.right_status (st[RI]),
				.right_total  (tot[RI]),
				.status       (st[j]),
				.total        (tot[j]),
				.ok_left      (okl[j]),
				.ok_right     (okr[j])
			);
			assign hv[j] = (st[j] == frra_pkg::ST_HUNGRY);
		end
	endgenerate

	// grant decisions
	logic grant_req;
	logic grant_l;
	logic grant_r;

	assign grant_req = okl[a] && okr[a];
	// with two agents the far side of a neighbour is the releasing agent itself;
	// with three the right neighbour's far side is the left one, maybe just granted
	assign grant_l = hv[l] && ((NUM_AGENTS == 2) || okl[l]);
	assign grant_r = (NUM_AGENTS == 2) ? (hv[r] && !grant_l)
	                                   : (hv[r] && okr[r] && !((NUM_AGENTS == 3) && grant_l));

	logic do_req;
	logic do_rel;

	assign do_req = proceed && in_range && (op_s1 == frra_pkg::OP_REQUEST);
	assign do_rel = proceed && in_range && (op_s1 == frra_pkg::OP_RELEASE);

	always_comb begin
		for (int k = 0; k < NUM_AGENTS; k++) begin
			ctl[k].set_hungry = do_req && (a == AGW'(k));
			ctl[k].release_en = do_rel && (a == AGW'(k));
			ctl[k].grant      = (do_req && grant_req && (a == AGW'(k))) ||
			                    (do_rel && grant_l && (l == AGW'(k))) ||
			                    (do_rel && grant_r && (r == AGW'(k)));
			ctl[k].weight     = w_s1;
		end
	end

	// results of this beat
	logic [1:0]          n_res;
	frra_pkg::out_item_t item0;
	frra_pkg::out_item_t item1;
	logic [EW-1:0]       a_ext;
	logic [EW-1:0]       l_ext;
	logic [EW-1:0]       r_ext;

	assign a_ext = EW'(a);
	assign l_ext = EW'(l);
	assign r_ext = EW'(r);

	always_comb begin
		n_res       = 2'd0;
		item0.agent = a_ext[frra_pkg::AGENT_W-1:0];
		item0.last  = 1'b1;
		item1.agent = r_ext[frra_pkg::AGENT_W-1:0];
		item1.last  = 1'b1;
		if (in_range) begin
			unique case (op_s1)
				frra_pkg::OP_REQUEST: begin
					n_res = grant_req ? 2'd1 : 2'd0;
				end
				frra_pkg::OP_RELEASE: begin
					if (grant_l && grant_r) begin
						n_res       = 2'd2;
						item0.agent = l_ext[frra_pkg::AGENT_W-1:0];
						item0.last  = 1'b0;
					end else if (grant_l) begin
						n_res       = 2'd1;
						item0.agent = l_ext[frra_pkg::AGENT_W-1:0];
					end else if (grant_r) begin
						n_res       = 2'd1;
						item0.agent = r_ext[frra_pkg::AGENT_W-1:0];
					end
				end
				default: n_res = 2'd0;
			endcase
		end
	end

	frra_pkg::out_item_t out_item;

	frra_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (proceed),
		.load_cnt   (n_res),
		.load_item0 (item0),
		.load_item1 (item1),
		.can_load   (can_load),
		.out_valid  (m_axis_tvalid),
		.out_item   (out_item),
		.out_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {5'd0, out_item.agent};
	assign m_axis_tlast = out_item.last;

endmodule

@@ rtl/frra_cell.sv @@
// One agent of the ring: status and consumed total, with its neighbour checks.
module frra_cell (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  frra_pkg::cell_ctl_t                     ctl,
	input  frra_pkg::status_t                       left_status,
	input  logic [frra_pkg::TOTAL_W-1:0]            left_total,
	input  frra_pkg::status_t                       right_status,
	input  logic [frra_pkg::TOTAL_W-1:0]            right_total,
	output frra_pkg::status_t                       status,
	output logic [frra_pkg::TOTAL_W-1:0]            total,
	output logic                                    ok_left,
	output logic                                    ok_right
);

	frra_pkg::status_t                status_q;
	logic [frra_pkg::TOTAL_W-1:0]     total_q;
	logic [frra_pkg::TOTAL_W:0]       sum;

	assign sum = {1'b0, total_q} + (frra_pkg::TOTAL_W+1)'(ctl.weight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= frra_pkg::ST_THINKING;
			total_q  <= '0;
		end else begin
			priority if (ctl.grant) begin
				status_q <= frra_pkg::ST_EATING;
			end else if (ctl.set_hungry) begin
				status_q <= frra_pkg::ST_HUNGRY;
			end else if (ctl.release_en) begin
				status_q <= frra_pkg::ST_THINKING;
			end
			if (ctl.release_en) begin
				total_q <= sum[frra_pkg::TOTAL_W] ? frra_pkg::TOTAL_MAX
				                                  : sum[frra_pkg::TOTAL_W-1:0];
			end
		end
	end

	// a neighbour blocks if eating, or hungry with a strictly smaller total
	assign ok_left  = (left_status != frra_pkg::ST_EATING) &&
	                  !((left_status == frra_pkg::ST_HUNGRY) && (left_total < total_q));
	assign ok_right = (right_status != frra_pkg::ST_EATING) &&
	                  !((right_status == frra_pkg::ST_HUNGRY) && (right_total < total_q));

	assign status = status_q;
	assign total  = total_q;

endmodule

@@ rtl/frra_out_buf.sv @@
// Two-slot result register feeding the master stream.
module frra_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [1:0]            load_cnt,
	input  frra_pkg::out_item_t   load_item0,
	input  frra_pkg::out_item_t   load_item1,
	output logic                  can_load,
	output logic                  out_valid,
	output frra_pkg::out_item_t   out_item,
	input  logic                  out_ready
);

	logic [1:0]          cnt_q;
	frra_pkg::out_item_t slot0_q;
	frra_pkg::out_item_t slot1_q;
	logic                pop;

	assign pop      = (cnt_q != 2'd0) && out_ready;
	// new results only once the slots will be empty after this edge
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (load) begin
				cnt_q <= load_cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= load_item0;
			slot1_q <= load_item1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot0_q;

endmodule

@@ sim/fair_ring_resource_arbiter_tb.sv @@
// Self-checking testbench for the fair ring resource arbiter: directed, heavy-use and random traffic.
`timescale 1ns / 100ps

module fair_ring_resource_arbiter_tb;

	localparam int N_AGENTS    = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 38;
	localparam int AGENT_W     = frra_pkg::AGENT_W;
	localparam int WEIGHT_W    = frra_pkg::WEIGHT_W;
	localparam int TOTAL_W     = frra_pkg::TOTAL_W;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = frra_pkg::TOTAL_MAX;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	// Predicted ring state
	frra_pkg::status_t   seat_state [N_AGENTS];
	logic [TOTAL_W-1:0]  seat_total [N_AGENTS];
	frra_pkg::out_item_t grant_q [$];

	int  fail_count;
	int  cycle_count;
	bit  calm;

	fair_ring_resource_arbiter #(
		.NUM_AGENTS(N_AGENTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic int left_seat(int a);
		return (a + N_AGENTS - 1) % N_AGENTS;
	endfunction

	function automatic int right_seat(int a);
		return (a + 1) % N_AGENTS;
	endfunction

	// Grants a hungry seat if neither neighbour eats and no hungry neighbour has eaten less
	function automatic bit try_seat(int a);
		int l;
		int r;
		l = left_seat(a);
		r = right_seat(a);
		if (seat_state[a] != frra_pkg::ST_HUNGRY)
			return 1'b0;
		if (seat_state[l] == frra_pkg::ST_EATING || seat_state[r] == frra_pkg::ST_EATING)
			return 1'b0;
		if (seat_state[l] == frra_pkg::ST_HUNGRY && seat_total[l] < seat_total[a])
			return 1'b0;
		if (seat_state[r] == frra_pkg::ST_HUNGRY && seat_total[r] < seat_total[a])
			return 1'b0;
		seat_state[a] = frra_pkg::ST_EATING;
		return 1'b1;
	endfunction

	task automatic predict_grants(frra_pkg::op_t op, logic [AGENT_W-1:0] agent,
			logic [WEIGHT_W-1:0] weight);
		int                  seats [$];
		int                  a;
		int                  sum;
		frra_pkg::out_item_t item;
		if (agent >= N_AGENTS)
			return;
		a = agent;
		if (op == frra_pkg::OP_REQUEST) begin
			seat_state[a] = frra_pkg::ST_HUNGRY;
			if (try_seat(a))
				seats.push_back(a);
		end else begin
			sum = seat_total[a] + weight;
			seat_total[a] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
			seat_state[a] = frra_pkg::ST_THINKING;
			if (try_seat(left_seat(a)))
				seats.push_back(left_seat(a));
			if (try_seat(right_seat(a)))
				seats.push_back(right_seat(a));
		end
		foreach (seats[k]) begin
			item.agent = seats[k][AGENT_W-1:0];
			item.last  = (k == seats.size() - 1);
			grant_q.push_back(item);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// tvalid stays high on return, so back-to-back beats keep it high unless the next beat draws an idle.
	task automatic send_beat(frra_pkg::op_t op, logic [AGENT_W-1:0] agent,
			logic [WEIGHT_W-1:0] weight);
		while (idle_now()) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {1'b0, weight, agent};
		s_axis_tuser  = op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_grants(op, agent, weight);
		@(negedge clk);
	endtask

	task automatic send_random_beat();
		int                  roll;
		int                  eaters [$];
		logic [WEIGHT_W-1:0] w;
		roll = $urandom_range(99);
		w    = WEIGHT_W'($urandom_range(15));
		for (int i = 0; i < N_AGENTS; i++)
			if (seat_state[i] == frra_pkg::ST_EATING)
				eaters.push_back(i);
		if (roll < 8)
			send_beat(frra_pkg::op_t'($urandom_range(1)),
				AGENT_W'($urandom_range(7, N_AGENTS)), w);
		else if (roll < 52)
			send_beat(frra_pkg::OP_REQUEST, AGENT_W'($urandom_range(N_AGENTS - 1)), w);
		else if (eaters.size() != 0 && roll < 90)
			send_beat(frra_pkg::OP_RELEASE,
				AGENT_W'(eaters[$urandom_range(eaters.size() - 1)]), w);
		else
			send_beat(frra_pkg::OP_RELEASE, AGENT_W'($urandom_range(N_AGENTS - 1)), w);
	endtask

	task automatic test_directed();
		send_beat(frra_pkg::OP_REQUEST, 3'd0, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd1, 4'd15);
		send_beat(frra_pkg::OP_REQUEST, 3'd0, 4'd0);   // re-request while eating
		send_beat(frra_pkg::OP_RELEASE, 3'd0, 4'd15);
		send_beat(frra_pkg::OP_REQUEST, 3'd4, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd3, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd0, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd0, 4'd0);   // re-request while hungry
		send_beat(frra_pkg::OP_RELEASE, 3'd4, 4'd0);
		send_beat(frra_pkg::OP_RELEASE, 3'd1, 4'd9);
		send_beat(frra_pkg::OP_RELEASE, 3'd2, 4'd15);  // release while thinking
		send_beat(frra_pkg::OP_REQUEST, 3'd2, 4'd0);
		send_beat(frra_pkg::OP_RELEASE, 3'd3, 4'd15);
		send_beat(frra_pkg::OP_REQUEST, 3'd5, 4'd15);  // indexes past the ring are dropped
		send_beat(frra_pkg::OP_RELEASE, 3'd6, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd7, 4'd15);
		send_beat(frra_pkg::OP_RELEASE, 3'd7, 4'd15);
		send_beat(frra_pkg::OP_RELEASE, 3'd0, 4'd0);
		send_beat(frra_pkg::OP_RELEASE, 3'd2, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd1, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd3, 4'd0);
		send_beat(frra_pkg::OP_REQUEST, 3'd2, 4'd0);
		send_beat(frra_pkg::OP_RELEASE, 3'd2, 4'd15);  // both neighbours may win here
	endtask

	// Pile weight onto one agent, with contention around it now and then
	task automatic test_heavy_use();
		for (int i = 0; i < 100; i++) begin
			send_beat(frra_pkg::OP_RELEASE, 3'd2, 4'd15);
			if (i % 25 == 0) begin
				send_beat(frra_pkg::OP_REQUEST, 3'd1, 4'd0);
				send_beat(frra_pkg::OP_REQUEST, 3'd3, 4'd0);
				send_beat(frra_pkg::OP_REQUEST, 3'd2, 4'd0);
			end
		end
		send_beat(frra_pkg::OP_REQUEST, 3'd2, 4'd0);
		send_beat(frra_pkg::OP_RELEASE, 3'd1, 4'd15);
		send_beat(frra_pkg::OP_RELEASE, 3'd3, 4'd15);
	endtask

	task automatic test_back_to_back();
		calm = 1'b1;
		repeat (120)
			send_random_beat();
		calm = 1'b0;
	endtask

	task automatic test_random_traffic();
		repeat (490)
			send_random_beat();
	endtask

	// Sink side: random back-pressure
	always @(negedge clk)
		m_axis_tready = !idle_now();

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (grant_q.size() == 0) begin
				$error("granted_agent: no grant expected, got %0d", m_axis_tdata[AGENT_W-1:0]);
				fail_count++;
			end else begin
				if (m_axis_tdata[AGENT_W-1:0] != grant_q[0].agent) begin
					$error("granted_agent: expected %0d, got %0d", grant_q[0].agent,
						m_axis_tdata[AGENT_W-1:0]);
					fail_count++;
				end
				if (m_axis_tlast != grant_q[0].last) begin
					$error("last: expected %0d, got %0d", grant_q[0].last, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tdata[7:AGENT_W] != '0) begin
					$error("tdata pad: expected 0, got %0h", m_axis_tdata[7:AGENT_W]);
					fail_count++;
				end
				void'(grant_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fair_ring_resource_arbiter: mismatch");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		calm          = 1'b0;
		fail_count    = 0;
		cycle_count   = 0;
		for (int i = 0; i < N_AGENTS; i++) begin
			seat_state[i] = frra_pkg::ST_THINKING;
			seat_total[i] = '0;
		end
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_heavy_use();
		test_back_to_back();
		test_random_traffic();
		s_axis_tvalid = 1'b0;

		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (fail_count == 0)
			$display("fair_ring_resource_arbiter: match");
		else
			$display("fair_ring_resource_arbiter: mismatch");
		$finish;
	end

endmodule
